/* hw/rtl/smes_pkg.sv */
package smes_pkg;

    localparam int INDEX_BITS = 16;
    localparam int KEY_W      = 2 * INDEX_BITS;
    localparam int VALUE_W    = 64;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 9;
    localparam int CFG_IDX_W  = 8;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 8'd1;

    localparam logic [INDEX_BITS-1:0] COUNT_RESET = 16'hFFFF;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_ACT,
        ST_DEL_RD,
        ST_DEL_WR,
        ST_INS_RD,
        ST_INS_WR,
        ST_FINISH
    } state_t;

endpackage

/* hw/rtl/sparse_matrix_element_store_top.sv */
// Operation: an in-range item scans the stored entries in key order until one is not
//   below its key or none are left, then reads or writes it; an insert or a removal
//   shifts the entries above it. An out-of-range item goes straight to its result.
// Throughput: one item at a time, the next accepted in the cycle after the result is
//   loaded; a stalled result holds the block. Reset: clears the entry count and
//   handshakes, sets both dimensions to 65535; table contents stay undefined.
module sparse_matrix_element_store_top import smes_pkg::*; #(
    parameter int CAPACITY = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [INDEX_BITS-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_req_type,
    input  logic [INDEX_BITS-1:0] s_row_index,
    input  logic [INDEX_BITS-1:0] s_col_index,
    input  logic [VALUE_W-1:0]    s_write_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [VALUE_W-1:0]    m_read_value,
    output logic [STATUS_W-1:0]   m_status,
    output logic [COUNT_W-1:0]    m_nonzero_count
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int PTR_W = $clog2(CAPACITY + 1);
    localparam logic [PTR_W-1:0] FULL_COUNT = PTR_W'(CAPACITY);

    state_t state_reg, state_next;

    logic [INDEX_BITS-1:0] row_count_reg;
    logic [INDEX_BITS-1:0] col_count_reg;
    logic [PTR_W-1:0]      total_reg;
    logic [PTR_W-1:0]      ptr_reg;
    logic [PTR_W-1:0]      mov_reg;
    logic                  hit_reg;
    logic                  req_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [VALUE_W-1:0]    value_reg;
    logic [VALUE_W-1:0]    res_value_reg;
    logic [STATUS_W-1:0]   res_status_reg;

    logic                  m_valid_reg;
    logic [VALUE_W-1:0]    m_read_value_reg;
    logic [STATUS_W-1:0]   m_status_reg;
    logic [COUNT_W-1:0]    m_count_reg;

    logic                  tbl_wr_en;
    logic [AW-1:0]         tbl_wr_addr;
    entry_t                tbl_wr_data;
    logic                  tbl_rd_en;
    logic [AW-1:0]         tbl_rd_addr;
    entry_t                tbl_rd_data;

    logic                  in_accept;
    logic                  in_range;
    logic                  zero_write;
    logic                  out_free;
    logic [PTR_W-1:0]      mov_inc;
    logic [PTR_W-1:0]      mov_dec;

    assign cfg_ready  = 1'b1;
    assign s_ready    = (state_reg == ST_IDLE);
    assign in_accept  = s_valid && s_ready;
    assign in_range   = (s_row_index < row_count_reg) && (s_col_index < col_count_reg);
    assign zero_write = (value_reg[VALUE_W-2:0] == '0);
    assign out_free   = !m_valid_reg || m_ready;
    assign mov_inc    = mov_reg + PTR_W'(1);
    assign mov_dec    = mov_reg - PTR_W'(1);

    assign m_valid         = m_valid_reg;
    assign m_read_value    = m_read_value_reg;
    assign m_status        = m_status_reg;
    assign m_nonzero_count = m_count_reg;

    smes_table #(
        .DEPTH (CAPACITY)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_wr_en),
        .wr_addr (tbl_wr_addr),
        .wr_data (tbl_wr_data),
        .rd_en   (tbl_rd_en),
        .rd_addr (tbl_rd_addr),
        .rd_data (tbl_rd_data)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = in_range ? ST_SCAN_RD : ST_FINISH;
                end
            end
            ST_SCAN_RD: begin
                state_next = (ptr_reg == total_reg) ? ST_ACT : ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                state_next = (tbl_rd_data.key < key_reg) ? ST_SCAN_RD : ST_ACT;
            end
            ST_ACT: begin
                if (req_reg == REQ_READ) begin
                    state_next = ST_FINISH;
                end else if (zero_write) begin
                    state_next = hit_reg ? ST_DEL_RD : ST_FINISH;
                end else if (hit_reg || total_reg == FULL_COUNT) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_INS_RD;
                end
            end
            ST_DEL_RD: begin
                state_next = (mov_inc < total_reg) ? ST_DEL_WR : ST_FINISH;
            end
            ST_DEL_WR: begin
                state_next = ST_DEL_RD;
            end
            ST_INS_RD: begin
                state_next = (mov_reg > ptr_reg) ? ST_INS_WR : ST_FINISH;
            end
            ST_INS_WR: begin
                state_next = ST_INS_RD;
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        tbl_wr_en   = 1'b0;
        tbl_wr_addr = ptr_reg[AW-1:0];
        tbl_wr_data = tbl_rd_data;
        tbl_rd_en   = 1'b0;
        tbl_rd_addr = ptr_reg[AW-1:0];
        case (state_reg)
            ST_SCAN_RD: begin
                tbl_rd_en   = (ptr_reg != total_reg);
                tbl_rd_addr = ptr_reg[AW-1:0];
            end
            ST_ACT: begin
                tbl_wr_en         = (req_reg == REQ_WRITE) && !zero_write && hit_reg;
                tbl_wr_addr       = ptr_reg[AW-1:0];
                tbl_wr_data.key   = key_reg;
                tbl_wr_data.value = value_reg;
            end
            ST_DEL_RD: begin
                tbl_rd_en   = (mov_inc < total_reg);
                tbl_rd_addr = mov_inc[AW-1:0];
            end
            ST_DEL_WR: begin
                tbl_wr_en   = 1'b1;
                tbl_wr_addr = mov_reg[AW-1:0];
            end
            ST_INS_RD: begin
                if (mov_reg > ptr_reg) begin
                    tbl_rd_en   = 1'b1;
                    tbl_rd_addr = mov_dec[AW-1:0];
                end else begin
                    tbl_wr_en         = 1'b1;
                    tbl_wr_addr       = ptr_reg[AW-1:0];
                    tbl_wr_data.key   = key_reg;
                    tbl_wr_data.value = value_reg;
                end
            end
            ST_INS_WR: begin
                tbl_wr_en   = 1'b1;
                tbl_wr_addr = mov_reg[AW-1:0];
            end
            default: begin
                tbl_wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            m_valid_reg   <= 1'b0;
            row_count_reg <= COUNT_RESET;
            col_count_reg <= COUNT_RESET;
        end else begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_ROW_COUNT) begin
                    row_count_reg <= cfg_data;
                end else if (cfg_index == CFG_COL_COUNT) begin
                    col_count_reg <= cfg_data;
                end
            end

            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_DEL_RD: begin
                    if (!(mov_inc < total_reg)) begin
                        total_reg <= total_reg - PTR_W'(1);
                    end
                end
                ST_INS_RD: begin
                    if (!(mov_reg > ptr_reg)) begin
                        total_reg <= total_reg + PTR_W'(1);
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                    end
                end
                default: begin
                    total_reg <= total_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                req_reg        <= s_req_type;
                key_reg        <= {s_row_index, s_col_index};
                value_reg      <= s_write_value;
                ptr_reg        <= '0;
                hit_reg        <= 1'b0;
                res_value_reg  <= '0;
                res_status_reg <= in_range ? STATUS_OK : STATUS_RANGE;
            end
            ST_SCAN_CMP: begin
                if (tbl_rd_data.key < key_reg) begin
                    ptr_reg <= ptr_reg + PTR_W'(1);
                end else begin
                    hit_reg <= (tbl_rd_data.key == key_reg);
                end
            end
            ST_ACT: begin
                if (req_reg == REQ_READ && hit_reg) begin
                    res_value_reg <= tbl_rd_data.value;
                end
                if (req_reg == REQ_WRITE && !zero_write && !hit_reg
                        && total_reg == FULL_COUNT) begin
                    res_status_reg <= STATUS_FULL;
                end
                mov_reg <= zero_write ? ptr_reg : total_reg;
            end
            ST_DEL_WR: begin
                mov_reg <= mov_inc;
            end
            ST_INS_WR: begin
                mov_reg <= mov_dec;
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_read_value_reg <= res_value_reg;
                    m_status_reg     <= res_status_reg;
                    m_count_reg      <= COUNT_W'(total_reg);
                end
            end
            default: begin
                mov_reg <= mov_reg;
            end
        endcase
    end

endmodule

/* hw/rtl/smes_table.sv */
module smes_table import smes_pkg::*; #(
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
